[design/color_key_clipped_blit_unit_assert.svh]
// Assertion macros shared by the blit unit RTL.
`ifndef COLOR_KEY_CLIPPED_BLIT_UNIT_ASSERT_SVH
`define COLOR_KEY_CLIPPED_BLIT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CKCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ckcb_pkg.sv]
// Types and constants of the color-keyed clipped blit unit.
package ckcb_pkg;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned KEY_W     = 24;
  localparam int unsigned ADDR_W    = 26;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned BYTES_PER_PIXEL = 3;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_DEST_X        = 3'd2,
    CFG_DEST_Y        = 3'd3,
    CFG_IMAGE_WIDTH   = 3'd4,
    CFG_IMAGE_HEIGHT  = 3'd5,
    CFG_KEY_ENABLE    = 3'd6,
    CFG_KEY_COLOR     = 3'd7
  } cfg_idx_e;

  // One framebuffer write result
  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_red;
    logic               last_pixel;
  } res_t;

endpackage

[design/ckcb_if.sv]
// Stream interfaces: source pixels in, framebuffer writes out.
interface ckcb_pix_if;
  logic                        valid;
  logic                        ready;
  logic [ckcb_pkg::COLOR_W-1:0] src_red;
  logic [ckcb_pkg::COLOR_W-1:0] src_green;
  logic [ckcb_pkg::COLOR_W-1:0] src_blue;

  modport source (output valid, output src_red, output src_green, output src_blue,
                  input ready);
  modport sink   (input valid, input src_red, input src_green, input src_blue,
                  output ready);
endinterface

interface ckcb_wr_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [ckcb_pkg::ADDR_W-1:0]  byte_address;
  logic [ckcb_pkg::COLOR_W-1:0] out_blue;
  logic [ckcb_pkg::COLOR_W-1:0] out_green;
  logic [ckcb_pkg::COLOR_W-1:0] out_red;
  logic                        last_pixel;

  modport source (output valid, output write_enable, output byte_address,
                  output out_blue, output out_green, output out_red,
                  output last_pixel, input ready);
  modport sink   (input valid, input write_enable, input byte_address,
                  input out_blue, input out_green, input out_red,
                  input last_pixel, output ready);
endinterface

[design/color_key_clipped_blit_unit.sv]
// Top level of the color-keyed clipped 24-bit blit unit.
//
//  channel  dir  handshake          payload
//  pix_i    in   valid/ready        src_red, src_green, src_blue
//  wr_o     out  valid/ready        write_enable, byte_address, out_blue/green/red,
//                                   last_pixel
//  cfg      in   cfg_we_i (no wait) cfg_index_i, cfg_wdata_i
//
// One pixel per cycle, back to back, while pix_i.ready is high; results are registered.
// Clip, key and address logic sits between the counters and the result register.
// A register write restarts the image and holds pix_i.ready low in the cycle after it
// while dest_y * screen_width is registered; the same holds after reset.
// A result register plus a skid entry keep accepting while a result waits; ready
// drops only when both entries are full or while the row base settles.
`include "color_key_clipped_blit_unit_assert.svh"

module color_key_clipped_blit_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ckcb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ckcb_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  ckcb_pix_if.sink                          pix_i,
  ckcb_wr_if.source                         wr_o
);

  localparam int unsigned DW = ckcb_pkg::DIM_W;
  localparam int unsigned AW = ckcb_pkg::ADDR_W;
  localparam int unsigned CW = $clog2(MAX_DIM);
  // compare width: holds MAX_DIM itself and any 13-bit register value
  localparam int unsigned NW = (CW + 1 > DW) ? CW + 1 : DW;
  // signed screen coordinate width
  localparam int unsigned XW = NW + 1;
  localparam logic [NW-1:0] MAX_DIM_N = NW'(MAX_DIM);

  // Configuration registers
  logic [DW-1:0]                   screen_width_q, screen_height_q;
  logic [DW-1:0]                   dest_x_q, dest_y_q;
  logic [DW-1:0]                   image_width_q, image_height_q;
  logic                            key_enable_q;
  logic [ckcb_pkg::KEY_W-1:0]      key_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= DW'(640);
      screen_height_q <= DW'(480);
      dest_x_q        <= '0;
      dest_y_q        <= '0;
      image_width_q   <= DW'(1);
      image_height_q  <= DW'(1);
      key_enable_q    <= 1'b0;
      key_color_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (ckcb_pkg::cfg_idx_e'(cfg_index_i))
        ckcb_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_DEST_X:        dest_x_q        <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_DEST_Y:        dest_y_q        <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata_i[DW-1:0];
        ckcb_pkg::CFG_KEY_ENABLE:    key_enable_q    <= cfg_wdata_i[0];
        ckcb_pkg::CFG_KEY_COLOR:     key_color_q     <= cfg_wdata_i[ckcb_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Destination row base, registered from the configuration
  logic signed [DW-1:0]   dest_y_s;
  logic signed [DW:0]     screen_width_s;
  logic signed [2*DW:0]   base_prod;
  logic [AW-1:0]          base_init_q;

  assign dest_y_s       = $signed(dest_y_q);
  assign screen_width_s = $signed({1'b0, screen_width_q});
  assign base_prod      = dest_y_s * screen_width_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_init_q <= '0;
    end else begin
      base_init_q <= base_prod[AW-1:0];
    end
  end

  // Control state
  logic [CW-1:0] col_q, row_q;
  logic [AW-1:0] row_base_q;
  logic          fresh_q;   // row base still to be taken from base_init_q
  logic          settle_q;  // base_init_q not yet valid
  logic          out_v_q, skid_v_q;
  ckcb_pkg::res_t out_q, skid_q;

  logic          in_xfer, out_take;
  logic [AW-1:0] row_base_eff;

  assign pix_i.ready  = !skid_v_q && !settle_q;
  assign in_xfer      = pix_i.valid && pix_i.ready;
  assign out_take     = !out_v_q || wr_o.ready;
  assign row_base_eff = fresh_q ? base_init_q : row_base_q;

  // Clamped image dimensions
  logic [NW-1:0] iw, ih;
  assign iw = (image_width_q == '0 || NW'(image_width_q) > MAX_DIM_N)
              ? MAX_DIM_N : NW'(image_width_q);
  assign ih = (image_height_q == '0 || NW'(image_height_q) > MAX_DIM_N)
              ? MAX_DIM_N : NW'(image_height_q);

  // Screen position and clipping
  logic signed [XW-1:0] pos_x, pos_y;
  logic                 on_screen, keyed, end_col, last, we;
  logic [AW-1:0]        pix_index, addr;
  ckcb_pkg::res_t       res;

  assign pos_x = $signed({{(XW-DW){dest_x_q[DW-1]}}, dest_x_q})
               + $signed({{(XW-CW){1'b0}}, col_q});
  assign pos_y = $signed({{(XW-DW){dest_y_q[DW-1]}}, dest_y_q})
               + $signed({{(XW-CW){1'b0}}, row_q});

  assign on_screen = !pos_x[XW-1] && !pos_y[XW-1]
                   && (pos_x[XW-2:0] < NW'(screen_width_q))
                   && (pos_y[XW-2:0] < NW'(screen_height_q));
  assign keyed     = key_enable_q
                   && ({pix_i.src_red, pix_i.src_green, pix_i.src_blue} == key_color_q);
  assign end_col   = (NW'(col_q) + NW'(1)) >= iw;
  assign last      = end_col && ((NW'(row_q) + NW'(1)) >= ih);
  assign we        = on_screen && !keyed;

  // Byte address: (row base + x) * 3, modulo the address range
  assign pix_index = row_base_eff + AW'(pos_x);
  assign addr      = AW'(pix_index * AW'(ckcb_pkg::BYTES_PER_PIXEL));

  always_comb begin
    res.write_enable = we;
    res.byte_address = we ? addr : '0;
    res.out_blue     = we ? pix_i.src_blue  : '0;
    res.out_green    = we ? pix_i.src_green : '0;
    res.out_red      = we ? pix_i.src_red   : '0;
    res.last_pixel   = last;
  end

  // Counters and row base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      fresh_q    <= 1'b1;
      settle_q   <= 1'b1;
    end else begin
      settle_q <= cfg_we_i;
      if (cfg_we_i) begin
        col_q   <= '0;
        row_q   <= '0;
        fresh_q <= 1'b1;
      end else if (in_xfer) begin
        fresh_q <= 1'b0;
        priority if (last) begin
          col_q      <= '0;
          row_q      <= '0;
          row_base_q <= base_init_q;
        end else if (end_col) begin
          col_q      <= '0;
          row_q      <= row_q + CW'(1);
          row_base_q <= row_base_eff + AW'(screen_width_q);
        end else begin
          col_q      <= col_q + CW'(1);
          row_base_q <= row_base_eff;
        end
      end
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (in_xfer) begin
      skid_q <= res;
    end
  end

  assign wr_o.valid        = out_v_q;
  assign wr_o.write_enable = out_q.write_enable;
  assign wr_o.byte_address = out_q.byte_address;
  assign wr_o.out_blue     = out_q.out_blue;
  assign wr_o.out_green    = out_q.out_green;
  assign wr_o.out_red      = out_q.out_red;
  assign wr_o.last_pixel   = out_q.last_pixel;

  // Checks
  `CKCB_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_v_q, out_v_q,
                   "skid entry full while output register empty")
  `CKCB_ASSERT_NXT(a_cfg_blocks_input, clk_i, rst_ni, cfg_we_i, !pix_i.ready,
                   "pixel transfer allowed before row base settled")
  `CKCB_ASSERT_IMP(a_col_in_range, clk_i, rst_ni, 1'b1, NW'(col_q) < iw,
                   "column counter beyond image width")
  `CKCB_ASSERT_IMP(a_clipped_zero, clk_i, rst_ni, out_v_q && !out_q.write_enable,
                   out_q.byte_address == '0 && out_q.out_blue == '0
                   && out_q.out_green == '0 && out_q.out_red == '0,
                   "skipped pixel carries nonzero payload")

endmodule
